FILE: rtl/signed_integer_alu_assert.svh
// assertion macros for the signed integer alu
`ifndef SIGNED_INTEGER_ALU_ASSERT_SVH
`define SIGNED_INTEGER_ALU_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define SIA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

FILE: rtl/sia_pkg.sv
`default_nettype none
package sia_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 3;
  localparam int unsigned StWidth   = 2;
  // one divider cell per quotient bit
  localparam int unsigned NumCells  = DataWidth;

  typedef logic [DataWidth-1:0] data_t;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_REM = 3'd4
  } op_e;

  typedef enum logic [StWidth-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_OP   = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_e;

  // word moving down the cell chain
  typedef struct packed {
    logic                valid;
    logic [OpWidth-1:0]  op;
    logic [StWidth-1:0]  status;
    data_t               fast;   // add, sub or mul result
    logic                neg_q;
    logic                neg_r;
    data_t               divisor;
    data_t               rem;    // partial remainder
    data_t               quo;    // dividend bits shifted into quotient
  } cell_t;
endpackage
`default_nettype wire

FILE: rtl/sia_if.sv
`default_nettype none
interface sia_req_if import sia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OpWidth-1:0]  req_type;
  logic signed [DataWidth-1:0] operand_a;
  logic signed [DataWidth-1:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface sia_rsp_if import sia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic signed [DataWidth-1:0] result_value;
  logic [StWidth-1:0]  status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/signed_integer_alu.sv
// channel  dir  fields
// req      in   req_type[2:0], operand_a[31:0], operand_b[31:0]
// rsp      out  result_value[31:0], status[1:0]
// one word per cycle while rsp does not stall; each result passes through 34
// registers (entry stage, 32 divider cells, output stage), with one
// restoring division step per cell.
// the whole chain advances together; it stalls only when the output
// register holds a word that is not taken, so a stall on rsp backs up req.
// reset clears all valid bits at once; no clearing pass.
`default_nettype none
`include "signed_integer_alu_assert.svh"
module signed_integer_alu import sia_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sia_req_if.sink   req,
  sia_rsp_if.source rsp
);
  cell_t chain [NumCells+1];
  cell_t entry_d, entry_q;
  logic  adv;
  logic  out_valid_q;
  data_t out_value_q;
  logic [StWidth-1:0] out_status_q;
  data_t a, b, mag_a, mag_b, qv, rv, fin;
  data_t prod;

  assign adv = !out_valid_q || rsp.ready;
  assign req.ready = adv;
  assign a = req.operand_a;
  assign b = req.operand_b;
  assign mag_a = a[DataWidth-1] ? data_t'(-a) : a;
  assign mag_b = b[DataWidth-1] ? data_t'(-b) : b;
  assign prod = a * b;

  // decode, compute the add, sub and mul results and set up the division
  always_comb begin
    entry_d = '0;
    entry_d.valid   = req.valid;
    entry_d.op      = req.req_type;
    entry_d.divisor = mag_b;
    entry_d.quo     = mag_a;
    entry_d.neg_q   = a[DataWidth-1] ^ b[DataWidth-1];
    entry_d.neg_r   = a[DataWidth-1];
    entry_d.status  = ST_OK;
    case (req.req_type)
      OP_ADD: entry_d.fast = a + b;
      OP_SUB: entry_d.fast = a - b;
      OP_MUL: entry_d.fast = prod;
      OP_DIV, OP_REM: begin
        if (b == '0) entry_d.status = ST_DIV_ZERO;
      end
      default: entry_d.status = ST_BAD_OP;
    endcase
  end

  // entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (adv) begin
      entry_q <= entry_d;
    end
  end

  assign chain[0] = entry_q;

  // divider cells
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    sia_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .word_i(chain[i]),
      .word_o(chain[i+1])
    );
  end

  // sign fix-up and result select
  always_comb begin
    qv = chain[NumCells].neg_q ? data_t'(-chain[NumCells].quo) : chain[NumCells].quo;
    rv = chain[NumCells].neg_r ? data_t'(-chain[NumCells].rem) : chain[NumCells].rem;
    if (chain[NumCells].status != ST_OK) begin
      fin = '0;
    end else begin
      case (chain[NumCells].op)
        OP_DIV:  fin = qv;
        OP_REM:  fin = rv;
        default: fin = chain[NumCells].fast;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= chain[NumCells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_value_q  <= fin;
      out_status_q <= chain[NumCells].status;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.result_value = out_value_q;
  assign rsp.status       = out_status_q;

  `SIA_ASSERT(a_stall_holds, (out_valid_q && !rsp.ready) |=> $stable(out_value_q), "stall")
  `SIA_ASSERT(a_err_zero, (out_valid_q && out_status_q != ST_OK) |-> out_value_q == '0, "err")
  `SIA_ASSERT(a_ready_tie, req.ready == (!out_valid_q || rsp.ready), "ready")
endmodule
`default_nettype wire

FILE: rtl/sia_cell.sv
`default_nettype none
module sia_cell import sia_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire cell_t word_i,
  output cell_t      word_o
);
  cell_t word_d, word_q;
  logic [DataWidth:0] shifted;
  logic [DataWidth:0] diff;

  // one restoring division step
  always_comb begin
    shifted = {word_i.rem, word_i.quo[DataWidth-1]};
    diff    = shifted - {1'b0, word_i.divisor};
    word_d  = word_i;
    if (!diff[DataWidth]) begin
      word_d.rem = diff[DataWidth-1:0];
      word_d.quo = {word_i.quo[DataWidth-2:0], 1'b1};
    end else begin
      word_d.rem = shifted[DataWidth-1:0];
      word_d.quo = {word_i.quo[DataWidth-2:0], 1'b0};
    end
  end

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= word_d;
    end
  end

  assign word_o = word_q;
endmodule
`default_nettype wire
